@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("palette allocator assertion failed");

// Plain condition that must hold at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(lbl, cond) `ASSERT_CLK(lbl, cond)

`endif

@@ hdl/pca_pkg.sv @@
// ----------------------------------------------------------------------------
// pca_pkg
// Types, constants and helper functions of the palette color allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pca_pkg;

  localparam int ENTRIES    = 256;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int LINK_W     = IDX_W + 1;
  localparam int COLOR_W    = 32;
  localparam int DIST_W     = 18;

  localparam logic [LINK_W-1:0]     LINK_NONE = LINK_W'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COLOR_W-1:0]    ALPHA_ON  = 32'hff00_0000;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_ALLOC = 3'd2,
    OP_FREE  = 3'd3,
    OP_MAP   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_WALK,
    ST_FETCH,
    ST_MV_NRD,
    ST_MV_NWR,
    ST_MV_PRD,
    ST_MV_PWR,
    ST_MV_PUSH,
    ST_MV_HWR,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    K_FREE,
    K_FORCE,
    K_TAKE,
    K_BUMP
  } kind_t;

  typedef struct packed {
    logic [LINK_W-1:0]     prev_ptr;
    logic [LINK_W-1:0]     next_ptr;
    logic [COUNT_BITS-1:0] count;
  } link_t;

  function automatic logic link_ok(input logic [LINK_W-1:0] p);
    link_ok = (32'(p) < 32'(ENTRIES));
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    bump = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    chan_sq = 16'(d) * 16'(d);
  endfunction

  function automatic logic [DIST_W-1:0] color_dist(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
    color_dist = DIST_W'(chan_sq(a[23:16], b[23:16])) +
                 DIST_W'(chan_sq(a[15:8], b[15:8])) +
                 DIST_W'(chan_sq(a[7:0], b[7:0]));
  endfunction

endpackage

@@ hdl/pca_ram.sv @@
// ----------------------------------------------------------------------------
// pca_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/palette_color_allocator.sv @@
// ----------------------------------------------------------------------------
// palette_color_allocator
// Reference-counted color lookup table with used and free linked lists.
// ----------------------------------------------------------------------------
// Search allocate and map walk the used list at one entry per cycle; an exact
// search that misses with no free entry walks it again as a nearest search.
// One item is in work at a time; the link RAM port sets the walk rate.
// Reset is synchronous; a clearing pass over every link word then rebuilds the
// link table (in_tready stays low), while cfg writes are taken at any time outside reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module palette_color_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: index_mask register.
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // index[7:0], argb[39:8], pixel_value[71:40]
  input  logic [3:0]  in_tuser,   // op[2:0], use_given_index[3]
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // index_out[7:0], actual_color[39:8]
  output logic [1:0]  out_tuser   // status[0], newly_set[1]
);

  import pca_pkg::*;

  // Control registers.
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [LINK_W-1:0]   free_head_r, free_head_nxt;
  logic [LINK_W-1:0]   used_head_r, used_head_nxt;
  logic [31:0]         index_mask_r;
  logic                rdv_r, rdv_nxt;
  logic                d_v_r, d_v_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Working payload registers.
  op_t                 op_r, op_nxt;
  kind_t               kind_r, kind_nxt;
  logic [COLOR_W-1:0]  req_r, req_nxt;
  logic [IDX_W-1:0]    e_r, e_nxt;
  link_t               lk_r, lk_nxt;
  logic [COUNT_BITS-1:0] newc_r, newc_nxt;
  logic                dir_r, dir_nxt;      // 1: free list to used list
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic                near_r, near_nxt;
  logic [DIST_W-1:0]   d_r, d_nxt;
  logic [IDX_W-1:0]    d_idx_r, d_idx_nxt;
  logic [COLOR_W-1:0]  d_col_r, d_col_nxt;
  logic                any_r, any_nxt;
  logic                stop_r, stop_nxt;
  logic [DIST_W-1:0]   best_r, best_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [COLOR_W-1:0]  best_col_r, best_col_nxt;
  logic [LINK_W-1:0]   hb_r, hb_nxt;
  logic                res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [COLOR_W-1:0]  res_col_r, res_col_nxt;
  logic                res_new_r, res_new_nxt;
  logic [39:0]         out_tdata_r, out_tdata_nxt;
  logic [1:0]          out_tuser_r, out_tuser_nxt;

  // RAM ports.
  logic                cr_we;
  logic [IDX_W-1:0]    cr_waddr, cr_raddr;
  logic [COLOR_W-1:0]  cr_wdata, cr_rdata;
  logic                lr_we;
  logic [IDX_W-1:0]    lr_waddr, lr_raddr;
  link_t               lr_wdata;
  logic [$bits(link_t)-1:0] lr_rdata;

  // Input fields.
  op_t                 in_op;
  logic [7:0]          in_index;
  logic                in_given;
  logic [31:0]         in_argb;
  logic [31:0]         in_pixel;
  logic                idx_ok;
  logic [31:0]         masked;

  link_t               q;
  logic [DIST_W-1:0]   cand_dist;
  logic [LINK_W-1:0]   ha, hb, ha_new;

  assign in_op    = op_t'(in_tuser[2:0]);
  assign in_given = in_tuser[3];
  assign in_index = in_tdata[7:0];
  assign in_argb  = in_tdata[39:8];
  assign in_pixel = in_tdata[71:40];
  assign idx_ok   = (32'(in_index) < 32'(ENTRIES));
  assign masked   = in_pixel & index_mask_r;

  assign q         = link_t'(lr_rdata);
  assign cand_dist = color_dist(cr_rdata, req_r);

  // Heads of the list an entry leaves (ha) and the one it joins (hb).
  assign ha = dir_r ? free_head_r : used_head_r;
  assign hb = dir_r ? used_head_r : free_head_r;
  assign ha_new = (!link_ok(lk_r.prev_ptr) || ha == LINK_W'(e_r)) ? lk_r.next_ptr : ha;

  // Colors: undefined until written, so no clearing pass.
  pca_ram #(.WIDTH(COLOR_W), .DEPTH(ENTRIES)) u_color_ram (
    .clk   (clk),
    .we    (cr_we),
    .waddr (cr_waddr),
    .wdata (cr_wdata),
    .raddr (cr_raddr),
    .rdata (cr_rdata)
  );

  // Use counts and both list links of every entry.
  pca_ram #(.WIDTH($bits(link_t)), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (lr_we),
    .waddr (lr_waddr),
    .wdata (lr_wdata),
    .raddr (lr_raddr),
    .rdata (lr_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      free_head_r  <= '0;
      used_head_r  <= LINK_NONE;
      index_mask_r <= 32'h0000_00ff;
      rdv_r        <= 1'b0;
      d_v_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      free_head_r <= free_head_nxt;
      used_head_r <= used_head_nxt;
      rdv_r       <= rdv_nxt;
      d_v_r       <= d_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        index_mask_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    kind_r       <= kind_nxt;
    req_r        <= req_nxt;
    e_r          <= e_nxt;
    lk_r         <= lk_nxt;
    newc_r       <= newc_nxt;
    dir_r        <= dir_nxt;
    cur_r        <= cur_nxt;
    near_r       <= near_nxt;
    d_r          <= d_nxt;
    d_idx_r      <= d_idx_nxt;
    d_col_r      <= d_col_nxt;
    any_r        <= any_nxt;
    stop_r       <= stop_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    best_col_r   <= best_col_nxt;
    hb_r         <= hb_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_col_r    <= res_col_nxt;
    res_new_r    <= res_new_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    free_head_nxt  = free_head_r;
    used_head_nxt  = used_head_r;
    rdv_nxt        = rdv_r;
    d_v_nxt        = d_v_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    op_nxt         = op_r;
    kind_nxt       = kind_r;
    req_nxt        = req_r;
    e_nxt          = e_r;
    lk_nxt         = lk_r;
    newc_nxt       = newc_r;
    dir_nxt        = dir_r;
    cur_nxt        = cur_r;
    near_nxt       = near_r;
    d_nxt          = d_r;
    d_idx_nxt      = d_idx_r;
    d_col_nxt      = d_col_r;
    any_nxt        = any_r;
    stop_nxt       = stop_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_col_nxt   = best_col_r;
    hb_nxt         = hb_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_col_nxt    = res_col_r;
    res_new_nxt    = res_new_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    in_tready      = 1'b0;
    cr_we          = 1'b0;
    cr_waddr       = e_r;
    cr_wdata       = req_r;
    cr_raddr       = cur_r;
    lr_we          = 1'b0;
    lr_waddr       = e_r;
    lr_wdata       = lk_r;
    lr_raddr       = cur_r;

    unique case (state_r)
      ST_CLEAR: begin
        lr_we             = 1'b1;
        lr_waddr          = clr_cnt_r;
        lr_wdata.count    = '0;
        lr_wdata.next_ptr = LINK_W'(clr_cnt_r) + 1'b1;
        lr_wdata.prev_ptr = (clr_cnt_r == '0) ? LINK_NONE : LINK_W'(clr_cnt_r) - 1'b1;
        clr_cnt_nxt       = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt         = in_op;
          req_nxt        = (in_op == OP_ALLOC) ? (in_argb | ALPHA_ON) : in_argb;
          res_status_nxt = 1'b1;
          res_idx_nxt    = '0;
          res_col_nxt    = '0;
          res_new_nxt    = 1'b0;
          state_nxt      = ST_RESP;
          unique case (in_op)
            OP_WRITE: begin
              if (idx_ok) begin
                cr_we          = 1'b1;
                cr_waddr       = IDX_W'(in_index);
                cr_wdata       = in_argb;
                res_status_nxt = 1'b0;
              end
            end
            OP_READ: begin
              if (idx_ok) begin
                cr_raddr  = IDX_W'(in_index);
                state_nxt = ST_RD_WAIT;
              end
            end
            OP_ALLOC: begin
              if (in_given) begin
                if (idx_ok) begin
                  cr_we          = 1'b1;
                  cr_waddr       = IDX_W'(in_index);
                  cr_wdata       = in_argb | ALPHA_ON;
                  lr_raddr       = IDX_W'(in_index);
                  e_nxt          = IDX_W'(in_index);
                  kind_nxt       = K_FORCE;
                  res_status_nxt = 1'b0;
                  res_idx_nxt    = IDX_W'(in_index);
                  res_col_nxt    = in_argb | ALPHA_ON;
                  res_new_nxt    = 1'b1;
                  state_nxt      = ST_FETCH;
                end
              end else if (link_ok(used_head_r)) begin
                cr_raddr  = used_head_r[IDX_W-1:0];
                lr_raddr  = used_head_r[IDX_W-1:0];
                cur_nxt   = used_head_r[IDX_W-1:0];
                rdv_nxt   = 1'b1;
                near_nxt  = 1'b0;
                stop_nxt  = 1'b0;
                state_nxt = ST_WALK;
              end else if (link_ok(free_head_r)) begin
                // Empty used list: take the head of the free list.
                cr_we          = 1'b1;
                cr_waddr       = free_head_r[IDX_W-1:0];
                cr_wdata       = in_argb | ALPHA_ON;
                lr_raddr       = free_head_r[IDX_W-1:0];
                e_nxt          = free_head_r[IDX_W-1:0];
                kind_nxt       = K_TAKE;
                res_status_nxt = 1'b0;
                res_idx_nxt    = free_head_r[IDX_W-1:0];
                res_col_nxt    = in_argb | ALPHA_ON;
                res_new_nxt    = 1'b1;
                state_nxt      = ST_FETCH;
              end
            end
            OP_FREE: begin
              if (masked < 32'(ENTRIES)) begin
                lr_raddr  = masked[IDX_W-1:0];
                e_nxt     = masked[IDX_W-1:0];
                kind_nxt  = K_FREE;
                state_nxt = ST_FETCH;
              end
            end
            OP_MAP: begin
              if (link_ok(used_head_r)) begin
                cr_raddr  = used_head_r[IDX_W-1:0];
                lr_raddr  = used_head_r[IDX_W-1:0];
                cur_nxt   = used_head_r[IDX_W-1:0];
                rdv_nxt   = 1'b1;
                near_nxt  = 1'b1;
                any_nxt   = 1'b0;
                stop_nxt  = 1'b0;
                d_v_nxt   = 1'b0;
                state_nxt = ST_WALK;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_RD_WAIT: begin
        res_status_nxt = 1'b0;
        res_col_nxt    = cr_rdata;
        state_nxt      = ST_RESP;
      end

      ST_WALK: begin
        if (!near_r) begin
          // Exact search: one used entry per cycle.
          if (cr_rdata == req_r) begin
            lr_we          = 1'b1;
            lr_waddr       = cur_r;
            lr_wdata       = q;
            lr_wdata.count = bump(q.count);
            rdv_nxt        = 1'b0;
            res_status_nxt = 1'b0;
            res_idx_nxt    = cur_r;
            res_col_nxt    = req_r;
            state_nxt      = ST_RESP;
          end else if (link_ok(q.next_ptr)) begin
            cr_raddr = q.next_ptr[IDX_W-1:0];
            lr_raddr = q.next_ptr[IDX_W-1:0];
            cur_nxt  = q.next_ptr[IDX_W-1:0];
          end else if (link_ok(free_head_r)) begin
            cr_we          = 1'b1;
            cr_waddr       = free_head_r[IDX_W-1:0];
            cr_wdata       = req_r;
            lr_raddr       = free_head_r[IDX_W-1:0];
            e_nxt          = free_head_r[IDX_W-1:0];
            kind_nxt       = K_TAKE;
            rdv_nxt        = 1'b0;
            res_status_nxt = 1'b0;
            res_idx_nxt    = free_head_r[IDX_W-1:0];
            res_col_nxt    = req_r;
            res_new_nxt    = 1'b1;
            state_nxt      = ST_FETCH;
          end else begin
            // No match and no free entry: restart as a nearest search.
            cr_raddr = used_head_r[IDX_W-1:0];
            lr_raddr = used_head_r[IDX_W-1:0];
            cur_nxt  = used_head_r[IDX_W-1:0];
            near_nxt = 1'b1;
            any_nxt  = 1'b0;
            stop_nxt = 1'b0;
            d_v_nxt  = 1'b0;
          end
        end else begin
          // Stage one registers the distance of the entry just read.
          d_v_nxt   = rdv_r;
          d_nxt     = cand_dist;
          d_idx_nxt = cur_r;
          d_col_nxt = cr_rdata;
          rdv_nxt   = rdv_r && link_ok(q.next_ptr) && !stop_r;
          if (rdv_nxt) begin
            cr_raddr = q.next_ptr[IDX_W-1:0];
            lr_raddr = q.next_ptr[IDX_W-1:0];
            cur_nxt  = q.next_ptr[IDX_W-1:0];
          end
          // Stage two keeps the first entry with the least distance.
          if (d_v_r && !stop_r && (!any_r || d_r < best_r)) begin
            any_nxt      = 1'b1;
            best_nxt     = d_r;
            best_idx_nxt = d_idx_r;
            best_col_nxt = d_col_r;
            if (d_r == '0) begin
              stop_nxt = 1'b1;
            end
          end
          if (!rdv_r && !d_v_r) begin
            res_status_nxt = 1'b0;
            res_idx_nxt    = best_idx_r;
            res_col_nxt    = best_col_r;
            if (op_r == OP_ALLOC) begin
              lr_raddr  = best_idx_r;
              e_nxt     = best_idx_r;
              kind_nxt  = K_BUMP;
              state_nxt = ST_FETCH;
            end else begin
              state_nxt = ST_RESP;
            end
          end
        end
      end

      ST_FETCH: begin
        lk_nxt = q;
        case (kind_r)
          K_FREE: begin
            if (q.count == '0) begin
              state_nxt = ST_RESP;
            end else begin
              res_status_nxt = 1'b0;
              if (q.count == COUNT_BITS'(1)) begin
                dir_nxt   = 1'b0;
                newc_nxt  = '0;
                state_nxt = ST_MV_NRD;
              end else begin
                lr_we          = 1'b1;
                lr_wdata       = q;
                lr_wdata.count = q.count - 1'b1;
                state_nxt      = ST_RESP;
              end
            end
          end
          K_FORCE: begin
            if (q.count == '0) begin
              dir_nxt   = 1'b1;
              newc_nxt  = COUNT_BITS'(1);
              state_nxt = ST_MV_NRD;
            end else begin
              lr_we          = 1'b1;
              lr_wdata       = q;
              lr_wdata.count = bump(q.count);
              state_nxt      = ST_RESP;
            end
          end
          K_TAKE: begin
            dir_nxt   = 1'b1;
            newc_nxt  = COUNT_BITS'(1);
            state_nxt = ST_MV_NRD;
          end
          default: begin
            lr_we          = 1'b1;
            lr_wdata       = q;
            lr_wdata.count = bump(q.count);
            state_nxt      = ST_RESP;
          end
        endcase
      end

      ST_MV_NRD: begin
        if (link_ok(lk_r.next_ptr)) begin
          lr_raddr  = lk_r.next_ptr[IDX_W-1:0];
          state_nxt = ST_MV_NWR;
        end else begin
          state_nxt = ST_MV_PRD;
        end
      end

      ST_MV_NWR: begin
        lr_we             = 1'b1;
        lr_waddr          = lk_r.next_ptr[IDX_W-1:0];
        lr_wdata          = q;
        lr_wdata.prev_ptr = lk_r.prev_ptr;
        state_nxt         = ST_MV_PRD;
      end

      ST_MV_PRD: begin
        if (link_ok(lk_r.prev_ptr)) begin
          lr_raddr  = lk_r.prev_ptr[IDX_W-1:0];
          state_nxt = ST_MV_PWR;
        end else begin
          state_nxt = ST_MV_PUSH;
        end
      end

      ST_MV_PWR: begin
        lr_we             = 1'b1;
        lr_waddr          = lk_r.prev_ptr[IDX_W-1:0];
        lr_wdata          = q;
        lr_wdata.next_ptr = lk_r.next_ptr;
        state_nxt         = ST_MV_PUSH;
      end

      ST_MV_PUSH: begin
        lr_we             = 1'b1;
        lr_waddr          = e_r;
        lr_wdata.prev_ptr = LINK_NONE;
        lr_wdata.next_ptr = hb;
        lr_wdata.count    = newc_r;
        if (dir_r) begin
          free_head_nxt = ha_new;
          used_head_nxt = LINK_W'(e_r);
        end else begin
          used_head_nxt = ha_new;
          free_head_nxt = LINK_W'(e_r);
        end
        hb_nxt = hb;
        if (link_ok(hb)) begin
          lr_raddr  = hb[IDX_W-1:0];
          state_nxt = ST_MV_HWR;
        end else begin
          state_nxt = ST_RESP;
        end
      end

      ST_MV_HWR: begin
        lr_we             = 1'b1;
        lr_waddr          = hb_r[IDX_W-1:0];
        lr_wdata          = q;
        lr_wdata.prev_ptr = LINK_W'(e_r);
        state_nxt         = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {res_col_r, 8'(res_idx_r)};
          out_tuser_nxt = {res_new_r, res_status_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // An item is taken only when no other item is in work.
  `ASSERT_CLK(a_ready_idle_only, (state_r != ST_IDLE) |-> !in_tready)
  // An entry never heads both lists at once.
  `ASSERT_ALWAYS(a_heads_apart, !(link_ok(free_head_r) && link_ok(used_head_r)) || (free_head_r != used_head_r))
  // A new result appears only from the response step.
  `ASSERT_CLK(a_result_from_resp, $rose(out_tvalid) |-> ($past(state_r) == ST_RESP))
  // The clearing pass runs straight through to idle.
  `ASSERT_CLK(a_clear_flow, (state_r == ST_CLEAR) |=> (state_r == ST_CLEAR || state_r == ST_IDLE))

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the palette color allocator. A directed table and
// then phases of random items run against a predictor of the table, both
// linked lists and the use counts, under several idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pca_pkg::*;

  // Codes past the last defined operation are answered with an error.
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam int NONE = ENTRIES;
  // A search allocate that misses with no free entry walks the used list twice.
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 100;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic        status;
    logic [7:0]  idx;
    logic [31:0] color;
    logic        newly;
  } palette_res_t;

  typedef struct packed {
    logic [2:0]   op;
    logic [7:0]   idx;
    logic         given;
    logic [31:0]  argb;
    logic [31:0]  pix;
    logic         typed;
    palette_res_t want;
  } palette_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  palette_color_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Predicted palette state.
  logic [31:0] pal_color [ENTRIES];
  bit          pal_written [ENTRIES];
  int          pal_count [ENTRIES];
  int          pal_next [ENTRIES];
  int          pal_prev [ENTRIES];
  int          free_top;
  int          used_top;
  logic [31:0] pal_mask;

  palette_res_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  logic [31:0] color_pool [16];

  function automatic int sat_inc(input int c);
    return (c >= int'(COUNT_MAX)) ? int'(COUNT_MAX) : c + 1;
  endfunction

  // Detach entry e from the free list (from_used = 0) or the used list.
  task automatic list_unlink(input int e, input bit from_used);
    int p;
    int n;
    p = pal_prev[e];
    n = pal_next[e];
    if (n < ENTRIES) pal_prev[n] = p;
    if (p < ENTRIES) pal_next[p] = n;
    else if (from_used) used_top = n;
    else free_top = n;
    if (from_used && used_top == e) used_top = n;
    if (!from_used && free_top == e) free_top = n;
  endtask

  task automatic list_push(input int e, input bit to_used);
    int h;
    h = to_used ? used_top : free_top;
    pal_next[e] = h;
    pal_prev[e] = NONE;
    if (h < ENTRIES) pal_prev[h] = e;
    if (to_used) used_top = e;
    else free_top = e;
  endtask

  function automatic int chan_err(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // First used entry with the least squared RGB distance, or -1 when empty.
  function automatic int nearest_used(input logic [31:0] c);
    int best;
    int found;
    int j;
    int steps;
    int err;
    best = -1;
    found = -1;
    j = used_top;
    steps = 0;
    while (j < ENTRIES && steps < ENTRIES) begin
      err = chan_err(pal_color[j][23:16], c[23:16]) + chan_err(pal_color[j][15:8], c[15:8]) +
            chan_err(pal_color[j][7:0], c[7:0]);
      if (found < 0 || err < best) begin
        best = err;
        found = j;
        if (err == 0) break;
      end
      j = pal_next[j];
      steps++;
    end
    return found;
  endfunction

  task automatic palette_predict(input palette_req_t r, output palette_res_t res);
    logic [31:0] req;
    logic [31:0] m;
    int j;
    int steps;
    bit hit;
    res = '0;
    res.status = 1'b1;
    req = r.argb | ALPHA_ON;
    case (r.op)
      OP_WRITE: begin
        pal_color[r.idx] = r.argb;
        pal_written[r.idx] = 1'b1;
        res.status = 1'b0;
      end
      OP_READ: begin
        res.color = pal_color[r.idx];
        res.status = 1'b0;
      end
      OP_ALLOC: begin
        if (r.given) begin
          if (pal_count[r.idx] == 0) begin
            list_unlink(r.idx, 1'b0);
            list_push(r.idx, 1'b1);
          end
          pal_color[r.idx] = req;
          pal_written[r.idx] = 1'b1;
          pal_count[r.idx] = sat_inc(pal_count[r.idx]);
          res = '{1'b0, r.idx, req, 1'b1};
        end else begin
          j = used_top;
          steps = 0;
          hit = 1'b0;
          while (j < ENTRIES && steps < ENTRIES) begin
            if (pal_color[j] == req) begin
              hit = 1'b1;
              break;
            end
            j = pal_next[j];
            steps++;
          end
          if (hit) begin
            pal_count[j] = sat_inc(pal_count[j]);
            res = '{1'b0, 8'(j), req, 1'b0};
          end else if (free_top < ENTRIES) begin
            j = free_top;
            list_unlink(j, 1'b0);
            list_push(j, 1'b1);
            pal_count[j] = 1;
            pal_color[j] = req;
            pal_written[j] = 1'b1;
            res = '{1'b0, 8'(j), req, 1'b1};
          end else begin
            j = nearest_used(req);
            if (j >= 0) begin
              pal_count[j] = sat_inc(pal_count[j]);
              res = '{1'b0, 8'(j), pal_color[j], 1'b0};
            end
          end
        end
      end
      OP_FREE: begin
        m = r.pix & pal_mask;
        if (m < ENTRIES && pal_count[m] != 0) begin
          pal_count[m]--;
          if (pal_count[m] == 0) begin
            list_unlink(m, 1'b1);
            list_push(m, 1'b0);
          end
          res.status = 1'b0;
        end
      end
      OP_MAP: begin
        j = nearest_used(r.argb);
        if (j >= 0) res = '{1'b0, 8'(j), pal_color[j], 1'b0};
      end
      default: ;
    endcase
  endtask

  // Offer one item; it is accepted at the first edge with in_tready high.
  task automatic send_item(input palette_req_t r);
    palette_res_t res;
    in_tvalid <= 1'b1;
    in_tdata  <= {r.pix, r.argb, r.idx};
    in_tuser  <= {r.given, r.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    palette_predict(r, res);
    pending_results.push_back(r.typed ? r.want : res);
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait for every pending result, then for the longest internal walk.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [31:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    pal_mask = v;
  endtask

  function automatic palette_req_t row(input logic [2:0] op, input logic [7:0] idx,
                                       input logic given, input logic [31:0] argb,
                                       input logic [31:0] pix, input logic typed,
                                       input palette_res_t want);
    return '{op, idx, given, argb, pix, typed, want};
  endfunction

  function automatic int pick_used();
    int tries;
    int e;
    for (tries = 0; tries < 64; tries++) begin
      e = $urandom_range(ENTRIES - 1);
      if (pal_count[e] != 0) return e;
    end
    return used_top < ENTRIES ? used_top : -1;
  endfunction

  // Random item shaped by the current palette; fill biases toward allocation.
  function automatic palette_req_t random_item(input bit fill);
    palette_req_t r;
    int pick;
    int e;
    r = '0;
    r.idx = 8'($urandom);
    r.given = 1'($urandom);
    r.argb = $urandom;
    r.pix = $urandom;
    pick = $urandom_range(99);
    if (fill) pick = (pick < 85) ? 0 : pick;
    if (pick < 35) begin
      r.op = OP_ALLOC;
      r.given = ($urandom_range(99) < 15);
      if (!fill && $urandom_range(99) < 60) r.argb = color_pool[$urandom_range(15)] ^
                                                   {8'($urandom), 24'h0};
    end else if (pick < 60) begin
      r.op = OP_FREE;
      e = pick_used();
      if (e >= 0 && $urandom_range(99) < 75) r.pix = ($urandom & ~pal_mask) | 32'(e);
    end else if (pick < 75) begin
      r.op = OP_MAP;
    end else if (pick < 85) begin
      r.op = OP_WRITE;
    end else if (pick < 95) begin
      // Only entries that hold a written color are ever read.
      r.op = OP_READ;
      while (!pal_written[r.idx]) r.idx = 8'($urandom);
    end else begin
      r.op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    end
    return r;
  endfunction

  task automatic random_phase(input int n, input bit fill);
    int k;
    for (k = 0; k < n; k++) send_item(random_item(fill));
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    palette_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: tdata %h tuser %h", out_tdata, out_tuser);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tuser[0] !== exp_res.status) begin
          $error("status: expected %h, got %h", exp_res.status, out_tuser[0]);
          errors++;
        end
        if (out_tdata[7:0] !== exp_res.idx) begin
          $error("index_out: expected %h, got %h", exp_res.idx, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[39:8] !== exp_res.color) begin
          $error("actual_color: expected %h, got %h", exp_res.color, out_tdata[39:8]);
          errors++;
        end
        if (out_tuser[1] !== exp_res.newly) begin
          $error("newly_set: expected %h, got %h", exp_res.newly, out_tuser[1]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  localparam palette_res_t RES_ERR = '{1'b1, 8'h00, 32'h0, 1'b0};
  localparam palette_res_t RES_OK  = '{1'b0, 8'h00, 32'h0, 1'b0};
  localparam palette_res_t NO_RES  = '0;

  initial begin
    palette_req_t directed[$];
    palette_req_t r;
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      pal_color[i] = '0;
      pal_written[i] = 1'b0;
      pal_count[i] = 0;
      pal_next[i] = (i + 1 < ENTRIES) ? i + 1 : NONE;
      pal_prev[i] = (i == 0) ? NONE : i - 1;
    end
    free_top = 0;
    used_top = NONE;
    pal_mask = 32'hff;
    for (i = 0; i < 16; i++) color_pool[i] = $urandom;

    // Directed table; typed rows carry their result, the rest use the predictor.
    directed.push_back(row(OP_MAP, 8'h00, 1'b0, 32'h0, 32'h0, 1'b1, RES_ERR));
    directed.push_back(row(OP_FREE, 8'h00, 1'b0, 32'h0, 32'h0, 1'b1, RES_ERR));
    directed.push_back(row(OP_UNDEF_LO, 8'h00, 1'b0, 32'h0, 32'h0, 1'b1, RES_ERR));
    directed.push_back(row(OP_UNDEF_HI, 8'hff, 1'b1, '1, '1, 1'b1, RES_ERR));
    directed.push_back(row(OP_ALLOC, 8'h00, 1'b0, 32'h0012_3456, 32'h0, 1'b1,
                           '{1'b0, 8'h00, 32'hff12_3456, 1'b1}));
    directed.push_back(row(OP_ALLOC, 8'h00, 1'b0, 32'h0012_3456, 32'h0, 1'b1,
                           '{1'b0, 8'h00, 32'hff12_3456, 1'b0}));
    directed.push_back(row(OP_ALLOC, 8'h00, 1'b0, '1, 32'h0, 1'b1,
                           '{1'b0, 8'h01, 32'hffff_ffff, 1'b1}));
    directed.push_back(row(OP_ALLOC, 8'h00, 1'b0, 32'h0, 32'h0, 1'b1,
                           '{1'b0, 8'h02, 32'hff00_0000, 1'b1}));
    directed.push_back(row(OP_WRITE, 8'hff, 1'b0, '1, 32'h0, 1'b1, RES_OK));
    directed.push_back(row(OP_READ, 8'hff, 1'b0, 32'h0, 32'h0, 1'b1,
                           '{1'b0, 8'h00, 32'hffff_ffff, 1'b0}));
    directed.push_back(row(OP_ALLOC, 8'hff, 1'b1, 32'h7f80_8080, 32'h0, 1'b1,
                           '{1'b0, 8'hff, 32'hff80_8080, 1'b1}));
    directed.push_back(row(OP_MAP, 8'h00, 1'b0, 32'h0081_8181, 32'h0, 1'b0, NO_RES));
    directed.push_back(row(OP_FREE, 8'h00, 1'b0, 32'h0, 32'hffff_ff00, 1'b1, RES_OK));
    directed.push_back(row(OP_FREE, 8'h00, 1'b0, 32'h0, 32'h0, 1'b1, RES_OK));
    directed.push_back(row(OP_FREE, 8'h00, 1'b0, 32'h0, 32'h0, 1'b1, RES_ERR));
    directed.push_back(row(OP_ALLOC, 8'h00, 1'b0, 32'h00ab_cdef, 32'h0, 1'b0, NO_RES));
    directed.push_back(row(OP_READ, 8'h00, 1'b0, 32'h0, 32'h0, 1'b0, NO_RES));
    directed.push_back(row(OP_ALLOC, 8'hff, 1'b1, 32'h0101_0101, 32'h0, 1'b0, NO_RES));
    directed.push_back(row(OP_MAP, 8'h00, 1'b0, 32'hff00_0000, 32'h0, 1'b0, NO_RES));
    directed.push_back(row(OP_MAP, 8'h00, 1'b0, '1, 32'h0, 1'b0, NO_RES));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows run with the reset mask and no idling.
    foreach (directed[k]) send_item(directed[k]);
    drain_block();

    write_mask(32'h0000_01ff);
    tx_idle_pct = 63;
    rx_stall_pct = 0;
    random_phase(100, 1'b0);
    drain_block();

    // Full-width mask; the receiver holds off long enough to back up the input.
    write_mask(32'hffff_ffff);
    tx_idle_pct = 0;
    rx_stall_pct = 63;
    hold_req = 1'b1;
    random_phase(100, 1'b0);
    drain_block();

    // Mask zero keeps frees on entry zero while allocation drains the free list.
    write_mask(32'h0);
    tx_idle_pct = 28;
    rx_stall_pct = 28;
    random_phase(300, 1'b1);
    random_phase(60, 1'b0);
    drain_block();

    write_mask($urandom);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    random_phase(60, 1'b0);
    drain_block();

    // Repeated forced allocation keeps bumping one entry that is in use.
    write_mask(32'h0000_00ff);
    r = row(OP_ALLOC, 8'h07, 1'b1, 32'h0033_6699, 32'h0, 1'b0, NO_RES);
    for (i = 0; i < 4; i++) send_item(r);
    send_item(row(OP_FREE, 8'h00, 1'b0, 32'h0, 32'h0000_0007, 1'b0, NO_RES));
    send_item(row(OP_READ, 8'h07, 1'b0, 32'h0, 32'h0, 1'b0, NO_RES));
    drain_block();

    $display("Ran %0d items and checked %0d results under several masks and idling mixes,",
             items_sent, results_seen);
    $display("with a full free list, the nearest-color fallback and repeated forced allocation.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
